FILE: design/elsh_pkg.sv
// Package with shared types, constants and codes for the Euclidean LSH hash unit.
`default_nettype none
package elsh_pkg;

    localparam int NUM_HASHES_DEF   = 16;
    localparam int DIM_DEF          = 256;
    localparam int ACC_W            = 48;
    localparam int SUM_W            = 49;
    localparam int COEF_W           = 16;
    localparam logic [31:0] BUCKET_WIDTH_RESET = 32'd67108864;

    localparam logic [1:0] OP_LOAD_COEF   = 2'd0;
    localparam logic [1:0] OP_LOAD_OFFSET = 2'd1;
    localparam logic [1:0] OP_FEATURE     = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         hash_index;
        logic [11:0]        element_index;
        logic signed [31:0] value;
        logic               last_element;
    } in_word_t;

    typedef struct packed {
        logic [5:0]         hash_number;
        logic signed [31:0] hash_value;
        logic               saturated;
        logic               last_hash;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_READ,
        ST_MAC_ADD,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } elsh_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_coef;
        logic load_offset;
        logic capture;
        logic mac_read;
        logic mac_add;
        logic div_start;
        logic div_step;
        logic clear_acc;
    } elsh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } elsh_stat_t;

    function automatic logic signed [COEF_W-1:0] sat_q213(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -32'sd32768) begin
            return 16'sh8000;
        end
        return v[COEF_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/elsh_datapath.sv
// Datapath: coefficient memory, offsets, accumulators, one MAC and a serial divider.
`default_nettype none
module elsh_datapath
    import elsh_pkg::*;
#(
    parameter int NUM_HASHES = NUM_HASHES_DEF,
    parameter int DIM        = DIM_DEF,
    localparam int HW        = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1,
    localparam int EW        = (DIM > 1) ? $clog2(DIM) : 1,
    localparam int AW        = (NUM_HASHES * DIM > 1) ? $clog2(NUM_HASHES * DIM) : 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_word_t    in_word,
    input  wire elsh_cmd_t   cmd,
    input  wire logic [HW-1:0] hash_sel,
    input  wire logic [31:0] bucket_width,
    output elsh_stat_t       stat,
    output logic signed [31:0] q_value,
    output logic             q_sat
);

    logic signed [COEF_W-1:0] coef_mem [NUM_HASHES*DIM];
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic signed [31:0]       offset_mem [NUM_HASHES];
    logic signed [ACC_W-1:0]  acc_reg [NUM_HASHES];
    logic signed [COEF_W-1:0] feat_reg;
    logic [EW-1:0]            elem_reg;
    logic signed [31:0]       prod;

    logic [HW-1:0] h_in;
    logic [EW-1:0] e_in;
    logic [AW-1:0] coef_wr_addr;
    logic [AW-1:0] coef_rd_addr;
    assign h_in = in_word.hash_index[HW-1:0];
    assign e_in = in_word.element_index[EW-1:0];
    assign coef_wr_addr = AW'(h_in) * AW'(DIM) + AW'(e_in);
    assign coef_rd_addr = AW'(hash_sel) * AW'(DIM) + AW'(elem_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_coef) begin
            coef_mem[coef_wr_addr] <= sat_q213(in_word.value);
        end
        if (cmd.mac_read) begin
            coef_rd_reg <= coef_mem[coef_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_offset) begin
            offset_mem[h_in] <= in_word.value;
        end
        if (cmd.capture) begin
            feat_reg <= sat_q213(in_word.value);
            elem_reg <= e_in;
        end
    end

    // Product of two Q2.13 numbers always fits in 32 bits.
    assign prod = coef_rd_reg * feat_reg;

    logic signed [SUM_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    assign acc_sum = SUM_W'(acc_reg[hash_sel]) + SUM_W'(prod);
    always_comb
    begin
        if (acc_sum > SUM_W'(48'sh7FFF_FFFF_FFFF)) begin
            acc_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (acc_sum < -SUM_W'(49'sh0_8000_0000_0000)) begin
            acc_sat = 48'sh8000_0000_0000;
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < NUM_HASHES; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (cmd.mac_add) begin
            acc_reg[hash_sel] <= acc_sat;
        end else if (cmd.clear_acc) begin
            acc_reg[hash_sel] <= '0;
        end
    end

    // Restoring divider on the magnitude, one quotient bit per cycle.
    logic [SUM_W-1:0] num_reg, num_next;
    logic [32:0]      rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next, zero_w_reg, zero_w_next;
    logic             busy_reg, busy_next, rnz_reg, rnz_next;
    logic signed [SUM_W-1:0] sum;
    logic [32:0]      trial;

    assign sum   = SUM_W'(acc_reg[hash_sel]) + SUM_W'(offset_mem[hash_sel]);
    assign trial = {rem_reg[31:0], num_reg[SUM_W-1]};

    always_comb
    begin
        num_next = num_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        neg_next = neg_reg; zero_w_next = zero_w_reg; busy_next = busy_reg;
        rnz_next = rnz_reg;
        if (cmd.div_start) begin
            neg_next    = sum[SUM_W-1];
            num_next    = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
            rem_next    = '0;
            cnt_next    = 6'(SUM_W);
            zero_w_next = (bucket_width == 32'd0);
            busy_next   = 1'b1;
        end else if (cmd.div_step && busy_reg) begin
            if (trial >= {1'b0, bucket_width}) begin
                rem_next = trial - {1'b0, bucket_width};
                num_next = {num_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                num_next = {num_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                rnz_next  = (rem_next != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        zero_w_reg <= zero_w_next;
        rnz_reg    <= rnz_next;
    end

    assign stat.div_done = !busy_reg && (cnt_reg == 6'd0);

    // Floor for negative sums: magnitude quotient rounded up, then negated.
    logic [SUM_W:0] mag;
    assign mag = {1'b0, num_reg} + {{SUM_W{1'b0}}, neg_reg & rnz_reg};
    always_comb
    begin
        if (zero_w_reg) begin
            q_sat   = 1'b1;
            q_value = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (!neg_reg && mag > (SUM_W+1)'(32'h7FFF_FFFF)) begin
            q_sat   = 1'b1;
            q_value = 32'sh7FFF_FFFF;
        end else if (neg_reg && mag > (SUM_W+1)'(33'h0_8000_0000)) begin
            q_sat   = 1'b1;
            q_value = 32'sh8000_0000;
        end else begin
            q_sat   = 1'b0;
            q_value = neg_reg ? -mag[31:0] : mag[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        assert (!(cmd.mac_add && cmd.clear_acc))
            else $error("accumulator add and clear together");
    end
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.div_start)
        else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_acc |=> acc_reg[$past(hash_sel)] == '0)
        else $error("accumulator not cleared");

endmodule
`default_nettype wire

FILE: design/elsh_ctrl.sv
// Controller state machine sequencing loads, MAC passes, divisions and result words.
`default_nettype none
module elsh_ctrl
    import elsh_pkg::*;
#(
    parameter int NUM_HASHES = NUM_HASHES_DEF,
    parameter int DIM        = DIM_DEF,
    localparam int HW        = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire elsh_stat_t  stat,
    output elsh_cmd_t        cmd,
    output logic [HW-1:0]    hash_sel,
    output logic             last_sel
);

    elsh_state_t   state_reg, state_next;
    logic [HW-1:0] k_reg, k_next;
    logic          last_reg, last_next;

    logic h_ok, e_ok;
    assign h_ok = in_word.hash_index < 7'(NUM_HASHES);
    assign e_ok = in_word.element_index < 13'(DIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    k_next = '0;
                    if (in_word.operation == OP_LOAD_COEF) begin
                        cmd.load_coef = h_ok && e_ok;
                    end else if (in_word.operation == OP_LOAD_OFFSET) begin
                        cmd.load_offset = h_ok;
                    end else if (in_word.operation == OP_FEATURE) begin
                        cmd.capture = 1'b1;
                        last_next   = in_word.last_element;
                        if (e_ok) begin
                            state_next = ST_MAC_READ;
                        end else if (in_word.last_element) begin
                            state_next = ST_DIV_START;
                        end
                    end
                end
            end
            ST_MAC_READ:
            begin
                cmd.mac_read = 1'b1;
                state_next   = ST_MAC_ADD;
            end
            ST_MAC_ADD:
            begin
                cmd.mac_add = 1'b1;
                if (k_reg == HW'(NUM_HASHES - 1)) begin
                    k_next     = '0;
                    state_next = last_reg ? ST_DIV_START : ST_IDLE;
                end else begin
                    k_next     = k_reg + HW'(1);
                    state_next = ST_MAC_READ;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.clear_acc = 1'b1;
                    if (k_reg == HW'(NUM_HASHES - 1)) begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + HW'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign hash_sel = k_reg;
    assign last_sel = (k_reg == HW'(NUM_HASHES - 1));

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result word waits");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(k_reg)))
        else $error("stalled result word changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac_add && k_reg == HW'(NUM_HASHES - 1) && !last_reg) |=> in_ready)
        else $error("did not return to idle after MAC pass");

endmodule
`default_nettype wire

FILE: design/euclidean_lsh_projection_hash.sv
// Top level of the p-stable Euclidean LSH projection hash unit.
// Input words on in_valid/in_ready load coefficients (operation 0), offsets
// (operation 1) or carry a feature element (operation 2). For a feature,
// one shared multiply-accumulate unit visits each hash row in turn, reading
// the coefficient memory through its single read port. A feature marked last
// then produces NUM_HASHES result words in hash order; each goes through the
// bit-serial divider (one quotient bit per cycle over the 49-bit sum). The
// result word is held while out_ready is low, and no input word is taken
// until all results are delivered.
// Reset clears the accumulators, control state and sets bucket_width to 1.0;
// coefficient and offset memories are undefined until loaded.
// bucket_width is written with cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
`default_nettype none
module euclidean_lsh_projection_hash
    import elsh_pkg::*;
#(
    parameter int NUM_HASHES = NUM_HASHES_DEF,
    parameter int DIM        = DIM_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_word_t        out_data
);

    localparam int HW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

    logic [31:0]        width_reg;
    elsh_cmd_t          cmd;
    elsh_stat_t         stat;
    logic [HW-1:0]      hash_sel;
    logic               last_sel;
    logic signed [31:0] q_value;
    logic               q_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg <= BUCKET_WIDTH_RESET;
        end else if (cfg_we) begin
            width_reg <= cfg_data;
        end
    end

    elsh_ctrl #(.NUM_HASHES(NUM_HASHES), .DIM(DIM)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd), .hash_sel(hash_sel), .last_sel(last_sel)
    );

    elsh_datapath #(.NUM_HASHES(NUM_HASHES), .DIM(DIM)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd),
        .hash_sel(hash_sel), .bucket_width(width_reg),
        .stat(stat), .q_value(q_value), .q_sat(q_sat)
    );

    assign out_data.hash_number = 6'(hash_sel);
    assign out_data.hash_value  = q_value;
    assign out_data.saturated   = q_sat;
    assign out_data.last_hash   = last_sel;

endmodule
`default_nettype wire

FILE: bench/euclidean_lsh_projection_hash_tb.sv
// Self-checking testbench for the Euclidean LSH projection hash unit.
`default_nettype none
module euclidean_lsh_projection_hash_tb;
    import elsh_pkg::*;

    localparam int NH = NUM_HASHES_DEF;
    localparam int DM = DIM_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
    localparam longint ACC_LO = -(64'sd1 <<< 47);
    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_word_t out_data;

    euclidean_lsh_projection_hash dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state.
    logic signed [15:0] coef_mem [NH*DM];
    logic signed [31:0] offset_mem [NH];
    longint             acc [NH];
    logic [31:0]        bucket_w = BUCKET_WIDTH_RESET;

    in_word_t  pending_words [$];
    out_word_t expected_hashes [$];
    int        errors = 0;
    bit        quiet = 1'b0;

    // Stimulus bookkeeping: an element is usable once all hash rows hold a coefficient.
    int rows_written [DM];
    bit row_seen [NH][DM];
    int usable_elems [$];

    function automatic logic signed [15:0] to_q213(logic signed [31:0] v);
        if (v > 32'sd32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    task automatic hash_model_step(in_word_t w);
        longint    a;
        longint    sum;
        longint    q;
        longint    wl;
        out_word_t r;
        int        e;
        int        h;
        e = int'(w.element_index);
        h = int'(w.hash_index);
        case (w.operation)
            OP_LOAD_COEF:
            begin
                if (h < NH && e < DM)
                begin
                    coef_mem[h*DM + e] = to_q213(w.value);
                end
            end
            OP_LOAD_OFFSET:
            begin
                if (h < NH)
                begin
                    offset_mem[h] = w.value;
                end
            end
            OP_FEATURE:
            begin
                if (e < DM)
                begin
                    for (int k = 0; k < NH; k++)
                    begin
                        a = acc[k] + longint'(coef_mem[k*DM + e]) * longint'(to_q213(w.value));
                        if (a > ACC_HI) a = ACC_HI;
                        if (a < ACC_LO) a = ACC_LO;
                        acc[k] = a;
                    end
                end
                if (w.last_element)
                begin
                    wl = longint'({32'd0, bucket_w});
                    for (int k = 0; k < NH; k++)
                    begin
                        sum = acc[k] + longint'(offset_mem[k]);
                        r = '0;
                        if (wl == 0)
                        begin
                            r.saturated = 1'b1;
                            q = (sum >= 0) ? Q_HI : Q_LO;
                        end
                        else
                        begin
                            q = sum / wl;
                            if (sum < 0 && (sum % wl) != 0) q = q - 1;
                            if (q > Q_HI)
                            begin
                                q = Q_HI;
                                r.saturated = 1'b1;
                            end
                            if (q < Q_LO)
                            begin
                                q = Q_LO;
                                r.saturated = 1'b1;
                            end
                        end
                        r.hash_number = k[5:0];
                        r.hash_value = q[31:0];
                        r.last_hash = (k == NH - 1);
                        expected_hashes.push_back(r);
                        acc[k] = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: launches queued words, holds them until taken.
    int gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hash_model_step(in_data);
            end
            if (in_valid && !in_ready)
            begin
                in_valid <= 1'b1;
            end
            else if (gap != 0)
            begin
                in_valid <= 1'b0;
                gap <= gap - 1;
            end
            else if (pending_words.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_words.pop_front();
                gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, checks each taken word, and a progress watchdog.
    int stall = 0;
    int idle_cycles = 0;
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word %p", out_data));
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (out_data.hash_number !== want.hash_number)
                        flag_mismatch($sformatf("hash_number %0d, want %0d",
                            out_data.hash_number, want.hash_number));
                    if (out_data.hash_value !== want.hash_value)
                        flag_mismatch($sformatf("hash %0d hash_value %0d, want %0d",
                            want.hash_number, out_data.hash_value, want.hash_value));
                    if (out_data.saturated !== want.saturated)
                        flag_mismatch($sformatf("hash %0d saturated %b, want %b",
                            want.hash_number, out_data.saturated, want.saturated));
                    if (out_data.last_hash !== want.last_hash)
                        flag_mismatch($sformatf("hash %0d last_hash %b, want %b",
                            want.hash_number, out_data.last_hash, want.last_hash));
                end
                stall <= pick_gap();
                out_ready <= (pick_gap() == 0);
            end
            else if (stall != 0)
            begin
                stall <= stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("** euclidean_lsh_projection_hash: FAILED **");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic in_word_t mk(logic [1:0] op, int h, int e, logic [31:0] v, bit last);
        in_word_t w;
        w.operation = op;
        w.hash_index = h[5:0];
        w.element_index = e[11:0];
        w.value = v;
        w.last_element = last;
        return w;
    endfunction

    function automatic logic [31:0] any_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 80000)) - 40000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
            default: return 32'($signed($urandom_range(0, 65535)) - 32768);
        endcase
    endfunction

    task automatic push_coef(int h, int e, logic [31:0] v, bit last);
        pending_words.push_back(mk(OP_LOAD_COEF, h, e, v, last));
        if (h < NH && e < DM && !row_seen[h][e])
        begin
            row_seen[h][e] = 1'b1;
            rows_written[e]++;
            if (rows_written[e] == NH) usable_elems.push_back(e);
        end
    endtask

    function automatic int usable_elem();
        return usable_elems[$urandom_range(0, usable_elems.size() - 1)];
    endfunction

    task automatic push_vector(int n);
        int e;
        for (int i = 0; i < n; i++)
        begin
            e = ($urandom_range(0, 9) == 0) ? $urandom_range(DM, 4095) : usable_elem();
            pending_words.push_back(mk(OP_FEATURE, $urandom_range(0, 63), e, any_value(),
                i == n - 1));
        end
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 5))
            0: push_coef($urandom_range(0, 63), $urandom_range(0, 4095), $urandom(), 1'b0);
            1: push_coef($urandom_range(0, NH - 1), usable_elem(), any_value(), 1'b0);
            2: pending_words.push_back(mk(OP_LOAD_OFFSET, $urandom_range(0, 63), 0,
                   $urandom(), $urandom_range(0, 1)));
            3: pending_words.push_back(mk(OP_UNUSED, $urandom_range(0, 63),
                   $urandom_range(0, 4095), $urandom(), $urandom_range(0, 1)));
            4: push_coef($urandom_range(0, NH - 1), usable_elem(), any_value(), 1'b1);
            default: pending_words.push_back(mk(OP_FEATURE, 0, usable_elem(), any_value(), 0));
        endcase
    endtask

    // Waits until the block is idle: all words sent, all results seen, then a margin.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_hashes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic set_width(logic [31:0] w);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= w;
        bucket_w = w;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] widths [6];
        int added;
        int n;
        for (int k = 0; k < NH; k++)
        begin
            acc[k] = 0;
            offset_mem[k] = '0;
        end
        for (int i = 0; i < NH*DM; i++) coef_mem[i] = '0;
        for (int e = 0; e < DM; e++) rows_written[e] = 0;
        widths[0] = 32'd1;
        widths[1] = 32'd0;
        widths[2] = 32'hFFFF_FFFF;
        widths[3] = $urandom_range(1, 32'h0400_0000);
        widths[4] = 32'h0010_0000;
        widths[5] = BUCKET_WIDTH_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the offsets and a handful of full coefficient columns first.
        for (int k = 0; k < NH; k++)
            pending_words.push_back(mk(OP_LOAD_OFFSET, k, 0, any_value(), 1'b0));
        for (int k = 0; k < NH; k++)
        begin
            push_coef(k, 0, any_value(), 1'b0);
            push_coef(k, DM - 1, any_value(), 1'b0);
        end
        for (int i = 0; i < 6; i++)
        begin
            added = $urandom_range(1, DM - 2);
            for (int k = 0; k < NH; k++) push_coef(k, added, any_value(), 1'b0);
        end

        // Directed: field extremes, ignored loads, the unused operation.
        push_coef(0, 0, 32'h7FFF_FFFF, 1'b0);
        push_coef(1, 0, 32'h8000_0000, 1'b0);
        pending_words.push_back(mk(OP_LOAD_OFFSET, 0, 0, 32'h7FFF_FFFF, 1'b0));
        pending_words.push_back(mk(OP_LOAD_OFFSET, 1, 0, 32'h8000_0000, 1'b1));
        push_coef(63, 4095, $urandom(), 1'b0);
        push_coef(0, 4095, $urandom(), 1'b1);
        push_coef(NH, 0, $urandom(), 1'b0);
        pending_words.push_back(mk(OP_LOAD_OFFSET, 63, 4095, $urandom(), 1'b0));
        pending_words.push_back(mk(OP_UNUSED, 63, 4095, 32'hFFFF_FFFF, 1'b1));
        pending_words.push_back(mk(OP_FEATURE, 0, 0, 32'h0000_7FFF, 1'b0));
        pending_words.push_back(mk(OP_FEATURE, 0, DM - 1, 32'hFFFF_8000, 1'b0));
        pending_words.push_back(mk(OP_FEATURE, 0, 0, 32'h7FFF_FFFF, 1'b0));
        pending_words.push_back(mk(OP_FEATURE, 63, 0, 32'h8000_0000, 1'b1));
        // A vector of only an out-of-range element still emits the hashes.
        pending_words.push_back(mk(OP_FEATURE, 0, 4095, $urandom(), 1'b1));

        for (int p = 0; p < 6; p++)
        begin
            set_width(widths[p]);
            quiet = (p == 2);
            if (p == 0)
            begin
                // With the smallest width four full-scale products clip the quotient.
                for (int i = 0; i < 4; i++)
                    pending_words.push_back(mk(OP_FEATURE, 0, 0, 32'h7FFF_FFFF, i == 3));
            end
            added = 0;
            while (added < 18)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    n = $urandom_range(1, 6);
                    push_vector(n);
                    added += n;
                end
                else
                begin
                    push_noise();
                    added++;
                end
            end
        end

        drain();
        if (errors == 0)
        begin
            $display("** euclidean_lsh_projection_hash: PASSED **");
        end
        else
        begin
            $display("** euclidean_lsh_projection_hash: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
